// ===== rtl/sawlc_pkg.sv =====
package sawlc_pkg;

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 3;

    // Storage geometry
    localparam int LINES   = 256;
    localparam int LINE_W  = 8;
    localparam int MAXB    = 16;
    localparam int OFF_W   = 4;
    localparam int MAXW    = 16;
    localparam int WAY_W   = 4;
    localparam int AGE_W   = 4;
    localparam int SET_W   = 8;
    localparam int DADDR_W = LINE_W + OFF_W;

    // Configuration register widths and indexes
    localparam int BLK_W   = 3;
    localparam int SLOG_W  = 4;
    localparam int WAYS_W  = 5;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 5;
    localparam int SH_W    = 4;
    localparam int BW_W    = 5;

    localparam logic [CIDX_W-1:0] CFG_BLOCK = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SETS  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_WAYS  = 2'd2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] K_READ  = 3'd0;
    localparam logic [KIND_W-1:0] K_WDONE = 3'd1;
    localparam logic [KIND_W-1:0] K_WB    = 3'd2;
    localparam logic [KIND_W-1:0] K_DROP  = 3'd3;
    localparam logic [KIND_W-1:0] K_REQ   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ADDR_W-1:0]        addr;
        logic signed [WORD_W-1:0] data;
    } t_item;

    // Effective geometry after saturation
    typedef struct packed {
        logic [BLK_W-1:0]  b;
        logic [SLOG_W-1:0] s;
        logic [WAYS_W-1:0] w;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic              valid;
        logic              dirty;
        logic [AGE_W-1:0]  age;
    } t_way;

    typedef t_way [MAXW-1:0] t_row;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD,
        S_WBR,
        S_WBE,
        S_DROP,
        S_REQ
    } t_state;

endpackage

// ===== rtl/sawlc_in_if.sv =====
interface sawlc_in_if;
    import sawlc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [ADDR_W-1:0]        address;
    logic signed [WORD_W-1:0] data;

    modport source (output valid, operation, address, data, input ready);
    modport sink   (input valid, operation, address, data, output ready);
endinterface

// ===== rtl/sawlc_out_if.sv =====
interface sawlc_out_if;
    import sawlc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [ADDR_W-1:0]        address_res;
    logic signed [WORD_W-1:0] data_res;
    logic                     last;

    modport source (output valid, kind, address_res, data_res, last, input ready);
    modport sink   (input valid, kind, address_res, data_res, last, output ready);
endinterface

// ===== rtl/set_assoc_writeback_lru_cache_unit.sv =====
// Channel | Dir | Transfer payload
// i_in    | in  | operation, address, data
// o_out   | out | kind, address_res, data_res, last
// i_cfg_* | in  | write enable, register index, data (no handshake)
//
// A read hit passes S_LOOK and S_RD after it leaves the two-entry input queue, a write
// hit S_LOOK only; a miss adds S_WBR and S_WBE per writeback word, S_WBR for the
// registered read of the word memory, and a state per notice. Fill words go straight to the word memory.
// Reset and any register write clear all line state; no clearing pass is needed.
// A stalled output holds its result; the input queue keeps accepting until full.
module set_assoc_writeback_lru_cache_unit import sawlc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CDAT_W-1:0] i_cfg_data,
    sawlc_in_if.sink          i_in,
    sawlc_out_if.source       o_out
);

    logic [BLK_W-1:0]  r_blk;
    logic [SLOG_W-1:0] r_slog;
    logic [WAYS_W-1:0] r_ways;
    logic              reinit;
    t_cfg              cfg;
    logic              pop, avail;
    t_item             item;

    // Raw configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk  <= '0;
            r_slog <= '0;
            r_ways <= WAYS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK: r_blk  <= i_cfg_data[BLK_W-1:0];
                CFG_SETS:  r_slog <= i_cfg_data[SLOG_W-1:0];
                CFG_WAYS:  r_ways <= i_cfg_data[WAYS_W-1:0];
                default:   ;
            endcase
        end
    end

    assign reinit = i_cfg_we && (i_cfg_index == CFG_BLOCK || i_cfg_index == CFG_SETS
                                 || i_cfg_index == CFG_WAYS);

    // Saturate geometry so that a line fits its words and ways times sets fits the line store
    always_comb begin
        cfg.b = (r_blk > BLK_W'(OFF_W)) ? BLK_W'(OFF_W) : r_blk;
        if (r_ways == '0) cfg.w = WAYS_W'(1);
        else if (r_ways > WAYS_W'(MAXW)) cfg.w = WAYS_W'(MAXW);
        else cfg.w = r_ways;
        cfg.s = '0;
        for (int k = 1; k < 16; k++) begin
            if (SLOG_W'(k) <= r_slog && (20'(cfg.w) << k) <= 20'(LINES)) begin
                cfg.s = SLOG_W'(k);
            end
        end
    end

    sawlc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_avail (avail),
        .o_item  (item)
    );

    sawlc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_reinit (reinit),
        .i_avail  (avail),
        .i_item   (item),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/sawlc_front.sv =====
module sawlc_front import sawlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sawlc_in_if.sink    i_in,
    input  logic        i_pop,
    output logic        o_avail,
    output t_item       o_item
);

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       acc, push;

    // Two-entry queue; unused opcode is dropped at entry
    assign i_in.ready = (r_cnt != 2'd2);
    assign acc        = i_in.valid && i_in.ready;
    assign push       = acc && (i_in.operation != OP_NONE);
    assign o_avail    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_in.operation, addr: i_in.address, data: i_in.data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

// ===== rtl/sawlc_back.sv =====
module sawlc_back import sawlc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_reinit,
    input  logic        i_avail,
    input  t_item       i_item,
    output logic        o_pop,
    sawlc_out_if.source o_out
);

    // Storage
    t_row                     m_row  [LINES];
    logic signed [WORD_W-1:0] m_data [LINES*MAXB];
    logic [LINES-1:0]         r_rowvalid;

    t_row                     r_row_mem;
    logic                     r_rowdef;
    logic signed [WORD_W-1:0] r_rdata;

    // Control state
    t_state             r_state, n_state;
    t_item              r_cur, n_cur, r_pacc, n_pacc;
    logic               r_fin, n_fin, r_pend, n_pend;
    logic [LINE_W-1:0]  r_vline, n_vline;
    logic [WAY_W-1:0]   r_vway, n_vway;
    logic [BW_W-1:0]    r_fcnt, n_fcnt;
    logic [OFF_W-1:0]   r_idx, n_idx;

    // Output register
    logic                     r_ovalid;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0]        r_oaddr, n_oaddr;
    logic signed [WORD_W-1:0] r_odata, n_odata;
    logic                     r_olast, n_olast;
    logic                     emit, can_emit;

    // Memory port controls
    logic                     row_re, row_we;
    logic [SET_W-1:0]         row_raddr;
    t_row                     row_wdata;
    logic                     dat_re, dat_we;
    logic [DADDR_W-1:0]       dat_raddr, dat_waddr;
    logic signed [WORD_W-1:0] dat_wdata;

    // Geometry
    logic [BW_W-1:0]   bw;
    logic [OFF_W-1:0]  bmask;
    logic [SH_W-1:0]   sh;
    logic [ADDR_W-1:0] smask;
    logic [AGE_W-1:0]  oldest;

    assign bw     = BW_W'(1) << i_cfg.b;
    assign bmask  = OFF_W'(bw - BW_W'(1));
    assign sh     = SH_W'(i_cfg.b) + i_cfg.s;
    assign smask  = (ADDR_W'(1) << i_cfg.s) - ADDR_W'(1);
    assign oldest = AGE_W'(i_cfg.w - WAYS_W'(1));

    function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a,
                                                input t_cfg c,
                                                input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] t;
        t = (a >> c.b) & m;
        return t[SET_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w,
                                                  input t_cfg c);
        logic [12:0] p;
        p = 13'(s) * 13'(c.w) + 13'(w);
        return p[LINE_W-1:0];
    endfunction

    // Current access fields
    logic [SET_W-1:0]  cur_set;
    logic [ADDR_W-1:0] cur_tag;
    logic [OFF_W-1:0]  cur_off;

    assign cur_set = set_of(r_cur.addr, i_cfg, smask);
    assign cur_tag = r_cur.addr >> sh;
    assign cur_off = r_cur.addr[OFF_W-1:0] & bmask;

    // Effective row: a set never written since reinit reads as reset
    t_row row, row_f, row_t, row_m;
    always_comb begin
        for (int i = 0; i < MAXW; i++) begin
            row[i].tag   = r_row_mem[i].tag;
            row[i].valid = r_row_mem[i].valid && !r_rowdef;
            row[i].dirty = r_row_mem[i].dirty && !r_rowdef;
            if (r_rowdef) begin
                row[i].age = (WAYS_W'(i) < i_cfg.w) ? AGE_W'(oldest - AGE_W'(i)) : '0;
            end else begin
                row[i].age = r_row_mem[i].age;
            end
        end
    end

    // Tag lookup and victim choice
    logic             hit;
    logic [WAY_W-1:0] hway, vict, uway;
    logic             vfound;
    always_comb begin
        hit    = 1'b0;
        hway   = '0;
        vict   = '0;
        vfound = 1'b0;
        for (int i = MAXW - 1; i >= 0; i--) begin
            if (WAYS_W'(i) < i_cfg.w && row[i].valid && row[i].tag == cur_tag) begin
                hit  = 1'b1;
                hway = WAY_W'(i);
            end
            if (WAYS_W'(i) < i_cfg.w && row[i].age == oldest) begin
                vfound = 1'b1;
                vict   = WAY_W'(i);
            end
        end
        if (!vfound) vict = '0;
    end

    // Row after a completed fill, then after the access touches it
    logic [AGE_W-1:0] uold;
    always_comb begin
        row_f = row;
        if (r_fin) begin
            row_f[r_vway].tag   = cur_tag;
            row_f[r_vway].valid = 1'b1;
            row_f[r_vway].dirty = 1'b0;
        end
        uway = r_fin ? r_vway : hway;
        uold = row_f[uway].age;
        row_t = row_f;
        for (int i = 0; i < MAXW; i++) begin
            if (WAYS_W'(i) < i_cfg.w && WAY_W'(i) != uway && row_f[i].age < uold) begin
                row_t[i].age = row_f[i].age + AGE_W'(1);
            end
        end
        row_t[uway].age = '0;
        if (r_cur.op == OP_WRITE) row_t[uway].dirty = 1'b1;
    end

    // Victim line invalidated when the fill is requested
    always_comb begin
        row_m = row;
        row_m[r_vway].valid = 1'b0;
        row_m[r_vway].dirty = 1'b0;
    end

    // Old line address for writeback and drop notices
    logic [ADDR_W-1:0] old_base;
    assign old_base = (row[r_vway].tag << sh) | (ADDR_W'(cur_set) << i_cfg.b);

    assign can_emit = !r_ovalid || o_out.ready;

    // Next state and datapath control
    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_fin     = r_fin;
        n_pend    = r_pend;
        n_pacc    = r_pacc;
        n_vline   = r_vline;
        n_vway    = r_vway;
        n_fcnt    = r_fcnt;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        emit      = 1'b0;
        n_kind    = r_kind;
        n_oaddr   = r_oaddr;
        n_odata   = r_odata;
        n_olast   = r_olast;
        row_re    = 1'b0;
        row_raddr = set_of(i_item.addr, i_cfg, smask);
        row_we    = 1'b0;
        row_wdata = row_t;
        dat_re    = 1'b0;
        dat_raddr = {line_of(cur_set, hway, i_cfg), cur_off};
        dat_we    = 1'b0;
        dat_waddr = {r_vline, r_fcnt[OFF_W-1:0]};
        dat_wdata = i_item.data;

        unique case (r_state)
            S_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    if (i_item.op == OP_FILL) begin
                        if (r_pend) begin
                            dat_we = 1'b1;
                            if (r_fcnt + BW_W'(1) == bw) begin
                                n_pend    = 1'b0;
                                n_fcnt    = '0;
                                n_cur     = r_pacc;
                                n_fin     = 1'b1;
                                row_re    = 1'b1;
                                row_raddr = set_of(r_pacc.addr, i_cfg, smask);
                                n_state   = S_LOOK;
                            end else begin
                                n_fcnt = r_fcnt + BW_W'(1);
                            end
                        end
                    end else if (!r_pend) begin
                        n_cur   = i_item;
                        n_fin   = 1'b0;
                        row_re  = 1'b1;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (r_fin || hit) begin
                    dat_raddr = {r_fin ? r_vline : line_of(cur_set, hway, i_cfg), cur_off};
                    if (r_cur.op == OP_WRITE) begin
                        if (can_emit) begin
                            row_we    = 1'b1;
                            dat_we    = 1'b1;
                            dat_waddr = dat_raddr;
                            dat_wdata = r_cur.data;
                            emit      = 1'b1;
                            n_kind    = K_WDONE;
                            n_oaddr   = r_cur.addr;
                            n_odata   = '0;
                            n_olast   = 1'b1;
                            n_fin     = 1'b0;
                            n_state   = S_IDLE;
                        end
                    end else begin
                        row_we  = 1'b1;
                        dat_re  = 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    n_vway  = vict;
                    n_vline = line_of(cur_set, vict, i_cfg);
                    n_idx   = '0;
                    if (row[vict].valid && row[vict].dirty) n_state = S_WBR;
                    else if (row[vict].valid) n_state = S_DROP;
                    else n_state = S_REQ;
                end
            end
            S_RD: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_kind  = K_READ;
                    n_oaddr = r_cur.addr;
                    n_odata = r_rdata;
                    n_olast = 1'b1;
                    n_fin   = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_WBR: begin
                dat_re    = 1'b1;
                dat_raddr = {r_vline, r_idx};
                n_state   = S_WBE;
            end
            S_WBE: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_kind  = K_WB;
                    n_oaddr = old_base | ADDR_W'(r_idx);
                    n_odata = r_rdata;
                    n_olast = 1'b0;
                    if (r_idx == bmask) begin
                        n_state = S_REQ;
                    end else begin
                        n_idx   = r_idx + OFF_W'(1);
                        n_state = S_WBR;
                    end
                end
            end
            S_DROP: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_kind  = K_DROP;
                    n_oaddr = old_base;
                    n_odata = '0;
                    n_olast = 1'b0;
                    n_state = S_REQ;
                end
            end
            S_REQ: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    n_kind    = K_REQ;
                    n_oaddr   = r_cur.addr & ~ADDR_W'(bmask);
                    n_odata   = WORD_W'(bw);
                    n_olast   = 1'b1;
                    row_we    = 1'b1;
                    row_wdata = row_m;
                    n_pend    = 1'b1;
                    n_fcnt    = '0;
                    n_pacc    = r_cur;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Row memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (row_we) m_row[cur_set] <= row_wdata;
        if (row_re) begin
            r_row_mem <= m_row[row_raddr];
            r_rowdef  <= !r_rowvalid[row_raddr];
        end
    end

    // Word memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (dat_we) m_data[dat_waddr] <= dat_wdata;
        if (dat_re) r_rdata <= m_data[dat_raddr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_reinit) begin
            r_state    <= S_IDLE;
            r_fin      <= 1'b0;
            r_pend     <= 1'b0;
            r_vline    <= '0;
            r_vway     <= '0;
            r_fcnt     <= '0;
            r_idx      <= '0;
            r_rowvalid <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_pend  <= n_pend;
            r_vline <= n_vline;
            r_vway  <= n_vway;
            r_fcnt  <= n_fcnt;
            r_idx   <= n_idx;
            if (row_we) r_rowvalid[cur_set] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_pacc  <= n_pacc;
        r_kind  <= n_kind;
        r_oaddr <= n_oaddr;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.kind        = r_kind;
    assign o_out.address_res = r_oaddr;
    assign o_out.data_res    = r_odata;
    assign o_out.last        = r_olast;

endmodule

// ===== tb/set_assoc_writeback_lru_cache_unit_test.sv =====
`timescale 1ns / 1ps

module set_assoc_writeback_lru_cache_unit_test;
    import sawlc_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
        logic              last;
    } cache_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
        bit                typed;
        cache_result_t     res;
    } access_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [CDAT_W-1:0] i_cfg_data;

    sawlc_in_if  in_if ();
    sawlc_out_if out_if ();

    set_assoc_writeback_lru_cache_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // Expected results, oldest first
    cache_result_t awaited_results[$];
    cache_result_t step_results[$];
    bit            failed;
    int            cycle_count;
    int            hold_until;
    int            send_gap_pct;
    int            take_gap_pct;
    int            sent_count;

    // Predicted cache state
    int              reg_blk, reg_sets, reg_ways;
    int              eb, es, ew;
    logic [15:0]     line_tag[LINES];
    bit              line_valid[LINES];
    bit              line_dirty[LINES];
    int              line_age[LINES];
    logic [31:0]     line_words[LINES*MAXB];
    bit              fill_busy;
    bit              pend_wr;
    logic [15:0]     pend_addr;
    logic [31:0]     pend_data;
    int              victim;
    int              fill_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Cycle budget
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver backpressure, with an optional long hold-off
    always @(negedge i_clk) begin
        if (cycle_count < hold_until)
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= take_gap_pct);
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        cache_result_t e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result kind=%0d addr=%h data=%h", out_if.kind,
                       out_if.address_res, out_if.data_res);
                failed = 1;
            end else begin
                e = awaited_results.pop_front();
                if (out_if.kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, out_if.kind);
                    failed = 1;
                end
                if (out_if.address_res !== e.addr) begin
                    $error("address_res: expected %h, got %h", e.addr, out_if.address_res);
                    failed = 1;
                end
                if (out_if.data_res !== e.data) begin
                    $error("data_res: expected %h, got %h", e.data, out_if.data_res);
                    failed = 1;
                end
                if (out_if.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, out_if.last);
                    failed = 1;
                end
            end
        end
    end

    // Apply register values with saturation and clear all line state
    function automatic void cache_reinit();
        eb = reg_blk;
        while (eb > 0 && (1 << eb) > MAXB) eb--;
        ew = reg_ways;
        if (ew < 1) ew = 1;
        if (ew > MAXW) ew = MAXW;
        es = reg_sets;
        while (es > 0 && (ew << es) > LINES) es--;
        for (int i = 0; i < LINES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 0;
            line_dirty[i] = 0;
            line_age[i]   = ew - 1 - (i % ew);
        end
        for (int i = 0; i < LINES*MAXB; i++) line_words[i] = '0;
        fill_busy  = 0;
        pend_wr    = 0;
        pend_addr  = '0;
        pend_data  = '0;
        victim     = 0;
        fill_count = 0;
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] k, logic [15:0] a,
                                        logic [31:0] d, logic l);
        cache_result_t r;
        r.kind = k;
        r.addr = a;
        r.data = d;
        r.last = l;
        step_results.push_back(r);
    endfunction

    // Hit path: access the word, then make the line most recent
    function automatic void touch_line(int ln, int base, bit wr, logic [15:0] a,
                                       logic [31:0] d);
        int idx;
        int old;
        idx = ln * MAXB + int'(a & ((16'd1 << eb) - 1));
        if (wr) begin
            line_words[idx] = d;
            line_dirty[ln]  = 1;
            push_result(K_WDONE, a, '0, 1'b1);
        end else begin
            push_result(K_READ, a, line_words[idx], 1'b1);
        end
        old = line_age[ln];
        for (int i = 0; i < ew; i++)
            if (base + i != ln && line_age[base + i] < old) line_age[base + i]++;
        line_age[ln] = 0;
    endfunction

    // Predict the results of one accepted input transfer into step_results
    function automatic void cache_model_step(logic [OP_W-1:0] op, logic [15:0] a,
                                             logic [31:0] d);
        int          bw, sh, set_no, base, vict;
        logic [15:0] tag, old;
        bw = 1 << eb;
        sh = eb + es;
        step_results.delete();
        if (op == OP_NONE) return;
        if (op == OP_FILL) begin
            if (!fill_busy || fill_count >= bw) return;
            line_words[victim * MAXB + fill_count] = d;
            fill_count++;
            if (fill_count < bw) return;
            set_no = int'((pend_addr >> eb) & ((16'd1 << es) - 1));
            line_tag[victim]   = pend_addr >> sh;
            line_valid[victim] = 1;
            line_dirty[victim] = 0;
            fill_busy  = 0;
            fill_count = 0;
            touch_line(victim, set_no * ew, pend_wr, pend_addr, pend_data);
            return;
        end
        if (fill_busy) return;
        set_no = int'((a >> eb) & ((16'd1 << es) - 1));
        base   = set_no * ew;
        tag    = a >> sh;
        for (int i = 0; i < ew; i++)
            if (line_valid[base + i] && line_tag[base + i] == tag) begin
                touch_line(base + i, base, op == OP_WRITE, a, d);
                return;
            end
        vict = base;
        for (int i = 0; i < ew; i++)
            if (line_age[base + i] == ew - 1) begin
                vict = base + i;
                break;
            end
        old = (line_tag[vict] << sh) | (16'(set_no) << eb);
        if (line_valid[vict] && line_dirty[vict]) begin
            for (int i = 0; i < bw; i++)
                push_result(K_WB, old | 16'(i), line_words[vict * MAXB + i], 1'b0);
        end else if (line_valid[vict]) begin
            push_result(K_DROP, old, '0, 1'b0);
        end
        push_result(K_REQ, a & ~16'(bw - 1), 32'(bw), 1'b1);
        line_valid[vict] = 0;
        line_dirty[vict] = 0;
        victim     = vict;
        fill_count = 0;
        fill_busy  = 1;
        pend_wr    = (op == OP_WRITE);
        pend_addr  = a;
        pend_data  = d;
    endfunction

    // One input transfer; valid is left high so back-to-back items stream
    task automatic send_access(logic [OP_W-1:0] op, logic [15:0] a, logic [31:0] d,
                               bit typed = 0, cache_result_t res = '{default: '0});
        while ($urandom_range(99) < send_gap_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid     = 1'b1;
        in_if.operation = op;
        in_if.address   = a;
        in_if.data      = d;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_count++;
        cache_model_step(op, a, d);
        if (typed) awaited_results.push_back(res);
        else foreach (step_results[i]) awaited_results.push_back(step_results[i]);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        if (idx == CFG_BLOCK) reg_blk = int'(val & 5'd7);
        else if (idx == CFG_SETS) reg_sets = int'(val & 5'd15);
        else reg_ways = int'(val);
        cache_reinit();
    endtask

    // Random traffic: mostly complete miss/fill sequences, some noise;
    // count is the least number of input transfers, fill words included
    task automatic run_random(int count);
        logic [15:0] a;
        int          span;
        int          start;
        start = sent_count;
        while (sent_count - start < count) begin
            span = eb + es + 2;
            if ($urandom_range(9) == 0) a = 16'($urandom);
            else a = 16'($urandom_range(0, (1 << span) - 1));
            case ($urandom_range(19))
                0: send_access(OP_NONE, a, $urandom);
                1: send_access(OP_FILL, a, $urandom);
                default: send_access($urandom_range(1) ? OP_WRITE : OP_READ, a, $urandom);
            endcase
            while (fill_busy) begin
                case ($urandom_range(15))
                    0: send_access($urandom_range(1) ? OP_WRITE : OP_READ,
                                   16'($urandom), $urandom);
                    1: send_access(OP_NONE, 16'($urandom), $urandom);
                    default: send_access(OP_FILL, 16'($urandom), $urandom);
                endcase
            end
        end
    endtask

    access_row_t directed_rows[$];

    function automatic access_row_t row(logic [OP_W-1:0] op, logic [15:0] a,
                                        logic [31:0] d, bit typed = 0,
                                        logic [KIND_W-1:0] k = K_READ,
                                        logic [15:0] ra = '0, logic [31:0] rd = '0);
        access_row_t r;
        r.op       = op;
        r.addr     = a;
        r.data     = d;
        r.typed    = typed;
        r.res.kind = k;
        r.res.addr = ra;
        r.res.data = rd;
        r.res.last = 1'b1;
        return r;
    endfunction

    // Register settings per phase, extremes and out-of-range values included
    int phase_blk[8]  = '{0, 2, 4, 0, 1, 7, 3, 2};
    int phase_sets[8] = '{0, 2, 0, 8, 4, 15, 1, 3};
    int phase_ways[8] = '{1, 2, 16, 1, 16, 31, 0, 4};

    initial begin
        hold_until   = 0;
        sent_count   = 0;
        send_gap_pct = 23;
        take_gap_pct = 83;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_BLOCK;
        i_cfg_data   = '0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_READ;
        in_if.address   = '0;
        in_if.data      = '0;
        reg_blk  = 0;
        reg_sets = 0;
        reg_ways = 1;
        cache_reinit();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at reset geometry: one word per line, one line
        directed_rows.push_back(row(OP_READ, 16'hFFFF, '0, 1, K_REQ, 16'hFFFF, 32'd1));
        directed_rows.push_back(row(OP_READ, 16'h1234, 32'h1));
        directed_rows.push_back(row(OP_FILL, 16'h0, 32'h7FFFFFFF, 1, K_READ, 16'hFFFF,
                                    32'h7FFFFFFF));
        directed_rows.push_back(row(OP_NONE, 16'hFFFF, 32'hFFFFFFFF));
        directed_rows.push_back(row(OP_FILL, 16'hFFFF, 32'h5));
        directed_rows.push_back(row(OP_WRITE, 16'hFFFF, 32'h80000000, 1, K_WDONE, 16'hFFFF,
                                    '0));
        directed_rows.push_back(row(OP_READ, 16'hFFFF, '0, 1, K_READ, 16'hFFFF,
                                    32'h80000000));
        directed_rows.push_back(row(OP_WRITE, 16'h0000, 32'h1));
        directed_rows.push_back(row(OP_FILL, 16'h0, 32'h0, 1, K_WDONE, 16'h0000, '0));
        directed_rows.push_back(row(OP_READ, 16'h0001, 32'hFFFFFFFF));
        directed_rows.push_back(row(OP_FILL, 16'hAAAA, 32'hFFFFFFFF));
        directed_rows.push_back(row(OP_READ, 16'h5555, 32'h0));
        directed_rows.push_back(row(OP_FILL, 16'h5555, 32'h55555555));
        directed_rows.push_back(row(OP_WRITE, 16'h5555, 32'hAAAAAAAA));
        foreach (directed_rows[i])
            send_access(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                        directed_rows[i].typed, directed_rows[i].res);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            if (p == 3) begin
                send_gap_pct = 83;
                take_gap_pct = 23;
            end else if (p == 6) begin
                send_gap_pct = 0;
                take_gap_pct = 0;
            end
            write_reg(CFG_BLOCK, 5'(phase_blk[p]));
            write_reg(CFG_SETS, 5'(phase_sets[p]));
            write_reg(CFG_WAYS, 5'(phase_ways[p]));
            if (p == 1) hold_until = cycle_count + 400;
            run_random(24);
            // Sender pause until all results are in
            if (p == 2) begin
                in_if.valid = 1'b0;
                while (awaited_results.size() != 0) @(negedge i_clk);
            end
            run_random(23);
            wait_drained();
        end

        if (!failed && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sawlc_pkg.sv
rtl/sawlc_in_if.sv
rtl/sawlc_out_if.sv
rtl/sawlc_front.sv
rtl/sawlc_back.sv
rtl/set_assoc_writeback_lru_cache_unit.sv
tb/set_assoc_writeback_lru_cache_unit_test.sv
